FILE: design/assert_macros.svh
// Assertion macros used by pid_with_filtered_terms_unit.
// Standalone header; the checks drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("check failed");
`else
`define CHK_IMPLY(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/pidft_pkg.sv
// Types and constants of the filtered-term PID unit.
// No dependencies; used by pid_with_filtered_terms_unit.
package pidft_pkg;

	localparam int DVD_W          = 82;
	localparam int WARMUP_DEFAULT = 3;

	localparam logic signed [23:0] C_MAX = 24'sd6553600;
	localparam logic signed [32:0] K_Q   = 33'sd92668;

	typedef enum logic [2:0] {
		REG_GAIN_PROP   = 3'd0,
		REG_GAIN_INTEG  = 3'd1,
		REG_GAIN_DERIV  = 3'd2,
		REG_EFF_UPPER   = 3'd3,
		REG_EFF_LOWER   = 3'd4,
		REG_INTEG_BOUND = 3'd5,
		REG_PERIOD      = 3'd6,
		REG_FILT_COEF   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INTEG,
		ST_CSQ,
		ST_KC,
		ST_COEF,
		ST_E_A2,
		ST_E_A1,
		ST_E_DIV,
		ST_D_A2,
		ST_D_A1,
		ST_D_DIV,
		ST_KP,
		ST_KI,
		ST_KD,
		ST_DONE
	} seq_state_t;

endpackage

FILE: design/pid_with_filtered_terms_unit.sv
// PID unit with Butterworth-filtered error and derivative terms, Q16.16.
// Depends on pidft_pkg and assert_macros.svh.
// The first beat after reset skips the arithmetic; warm-up beats skip the derivative filter.
// One beat at a time; the 82-step restoring divider (one bit a cycle, once per filter)
// and the shared 33x17 multiplier carry the arithmetic.
// Reset clears the sequencer, the histories, the integral and loads register defaults.
`include "assert_macros.svh"

module pid_with_filtered_terms_unit #(
	parameter int WARMUP_STEPS = pidft_pkg::WARMUP_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] measurement,
	input  logic signed [31:0] target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] effort,
	output logic               primed,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata
);

	// configuration registers
	logic signed [31:0] kp_q, ki_q, kd_q, upper_q, lower_q;
	logic [30:0]        bound_q, period_q;
	logic signed [23:0] coef_q;

	// controller state
	logic signed [32:0] err_q [3];
	logic signed [47:0] fe_q  [3];
	logic signed [32:0] dh_q  [3];
	logic signed [47:0] fd_q  [3];
	logic signed [31:0] integ_q;
	logic               started_q;
	logic [1:0]         warm_cnt_q;

	// filter coefficients
	logic [29:0]        c2_q;
	logic signed [24:0] kc_q;
	logic signed [31:0] a0_q, a1_q, a2_q;

	// sequencer, multiplier and divider
	pidft_pkg::seq_state_t state_q, state_d;
	logic [1:0]         ch_q;
	logic signed [49:0] pp_q;
	logic signed [80:0] acc_q;
	logic signed [65:0] num_q;
	logic [81:0]        dvd_q;
	logic [31:0]        rem_q;
	logic               neg_q;
	logic [6:0]         cnt_q;
	logic signed [65:0] eff_q;
	logic signed [31:0] res_eff_q;
	logic               res_primed_q;
	logic               out_valid_q;
	logic signed [31:0] out_eff_q;
	logic               out_primed_q;

	logic in_acc, out_free, warm, div_done;
	assign in_stall = (state_q != pidft_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign warm     = int'(warm_cnt_q) >= WARMUP_STEPS;
	assign div_done = (cnt_q == 7'(pidft_pkg::DVD_W));

	assign out_valid = out_valid_q;
	assign effort    = out_eff_q;
	assign primed    = out_primed_q;

	// clamp the filter coefficient to +-100.0
	logic signed [23:0] c_cl;
	always_comb begin
		if (coef_q > pidft_pkg::C_MAX)
			c_cl = pidft_pkg::C_MAX;
		else if (coef_q < -pidft_pkg::C_MAX)
			c_cl = -pidft_pkg::C_MAX;
		else
			c_cl = coef_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pidft_pkg::ST_IDLE:
				if (in_acc) begin
					if (!started_q || period_q == 31'd0)
						state_d = pidft_pkg::ST_DONE;
					else
						state_d = pidft_pkg::ST_INTEG;
				end
			pidft_pkg::ST_INTEG: if (ch_q == 2'd3) state_d = pidft_pkg::ST_CSQ;
			pidft_pkg::ST_CSQ:   if (ch_q == 2'd3) state_d = pidft_pkg::ST_KC;
			pidft_pkg::ST_KC:    if (ch_q == 2'd3) state_d = pidft_pkg::ST_COEF;
			pidft_pkg::ST_COEF:  state_d = pidft_pkg::ST_E_A2;
			pidft_pkg::ST_E_A2:  if (ch_q == 2'd3) state_d = pidft_pkg::ST_E_A1;
			pidft_pkg::ST_E_A1:  if (ch_q == 2'd3) state_d = pidft_pkg::ST_E_DIV;
			pidft_pkg::ST_E_DIV:
				if (div_done)
					state_d = warm ? pidft_pkg::ST_D_A2 : pidft_pkg::ST_KP;
			pidft_pkg::ST_D_A2:  if (ch_q == 2'd3) state_d = pidft_pkg::ST_D_A1;
			pidft_pkg::ST_D_A1:  if (ch_q == 2'd3) state_d = pidft_pkg::ST_D_DIV;
			pidft_pkg::ST_D_DIV: if (div_done) state_d = pidft_pkg::ST_KP;
			pidft_pkg::ST_KP:    if (ch_q == 2'd3) state_d = pidft_pkg::ST_KI;
			pidft_pkg::ST_KI:    if (ch_q == 2'd3) state_d = pidft_pkg::ST_KD;
			pidft_pkg::ST_KD:    if (ch_q == 2'd3) state_d = pidft_pkg::ST_DONE;
			pidft_pkg::ST_DONE:  if (out_free) state_d = pidft_pkg::ST_IDLE;
			default:             state_d = pidft_pkg::ST_IDLE;
		endcase
	end

	// multiplier operand selection per step; the filter feedback taps are the
	// outputs as they stand before this beat's shift (newest and one older)
	logic               mul_on;
	logic signed [32:0] mul_a;
	logic signed [47:0] mul_b;
	always_comb begin
		mul_on = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			pidft_pkg::ST_INTEG: begin
				mul_a = err_q[0];
				mul_b = {17'b0, period_q};
			end
			pidft_pkg::ST_CSQ: begin
				mul_a = 33'(c_cl);
				mul_b = 48'(c_cl);
			end
			pidft_pkg::ST_KC: begin
				mul_a = 33'(c_cl);
				mul_b = 48'(pidft_pkg::K_Q);
			end
			pidft_pkg::ST_E_A2: begin
				mul_a = 33'(a2_q);
				mul_b = fe_q[1];
			end
			pidft_pkg::ST_E_A1: begin
				mul_a = 33'(a1_q);
				mul_b = fe_q[0];
			end
			pidft_pkg::ST_D_A2: begin
				mul_a = 33'(a2_q);
				mul_b = fd_q[1];
			end
			pidft_pkg::ST_D_A1: begin
				mul_a = 33'(a1_q);
				mul_b = fd_q[0];
			end
			pidft_pkg::ST_KP: begin
				mul_a = 33'(kp_q);
				mul_b = fe_q[0];
			end
			pidft_pkg::ST_KI: begin
				mul_a = 33'(ki_q);
				mul_b = 48'(integ_q);
			end
			pidft_pkg::ST_KD: begin
				mul_a = 33'(kd_q);
				mul_b = fd_q[0];
			end
			default: mul_on = 1'b0;
		endcase
	end

	// shared multiplier: three 16-bit slices of B, product registered, then summed
	logic signed [16:0] chunk;
	logic signed [49:0] pp_d;
	logic signed [80:0] pp_ext, pp_sh, acc_sum;
	logic signed [64:0] prod_q16;
	always_comb begin
		case (ch_q)
			2'd0:    chunk = $signed({1'b0, mul_b[15:0]});
			2'd1:    chunk = $signed({1'b0, mul_b[31:16]});
			default: chunk = $signed({mul_b[47], mul_b[47:32]});
		endcase
		pp_d   = mul_a * chunk;
		pp_ext = 81'(pp_q);
		case (ch_q)
			2'd2:    pp_sh = pp_ext <<< 16;
			2'd3:    pp_sh = pp_ext <<< 32;
			default: pp_sh = pp_ext;
		endcase
		acc_sum  = ((ch_q == 2'd1) ? 81'sd0 : acc_q) + pp_sh;
		prod_q16 = acc_sum[80:16];
	end

	logic mul_last;
	assign mul_last = mul_on && (ch_q == 2'd3);

	// integral update with anti-windup clamp
	logic signed [49:0] integ_sum, bound_ext;
	logic signed [31:0] integ_new;
	always_comb begin
		integ_sum = 50'(integ_q) + prod_q16[49:0];
		bound_ext = $signed({19'b0, bound_q});
		if (integ_sum > bound_ext)
			integ_new = 32'(bound_ext);
		else if (integ_sum < -bound_ext)
			integ_new = 32'(-bound_ext);
		else
			integ_new = integ_sum[31:0];
	end

	// coefficients, error difference and filter numerator seed
	logic signed [32:0] a0_raw;
	logic signed [31:0] a1_new, a2_new;
	logic signed [33:0] diff_raw;
	logic signed [32:0] diff_sat;
	logic signed [65:0] num_err, num_diff, num_fin, num_abs;
	always_comb begin
		a0_raw   = 33'sd65536 + $signed({3'b0, c2_q}) + 33'(kc_q);
		a1_new   = 32'sd131072 - $signed({1'b0, c2_q, 1'b0});
		a2_new   = 32'sd65536 + $signed({2'b0, c2_q}) - 32'(kc_q);
		diff_raw = 34'(err_q[0]) - 34'(err_q[1]);
		if (diff_raw > 34'sh0_FFFF_FFFF)
			diff_sat = 33'sh0_FFFF_FFFF;
		else if (diff_raw < -34'sh1_0000_0000)
			diff_sat = 33'sh1_0000_0000;
		else
			diff_sat = diff_raw[32:0];
		num_err  = 66'(err_q[2]) + (66'(err_q[1]) <<< 1) + 66'(err_q[0]);
		num_diff = 66'(dh_q[2]) + (66'(dh_q[1]) <<< 1) + 66'(dh_q[0]);
		num_fin  = num_q - 66'(prod_q16);
		num_abs  = num_fin[65] ? -num_fin : num_fin;
	end

	// divider step and result shaping
	logic [32:0]        div_tr;
	logic               div_ge;
	logic [31:0]        rem_n;
	logic [65:0]        q_int;
	logic [32:0]        q_cl;
	logic signed [49:0] q_sgn;
	logic signed [47:0] div_res;
	always_comb begin
		div_tr = {rem_q, dvd_q[81]};
		div_ge = div_tr >= {1'b0, a0_q};
		rem_n  = div_ge ? 32'(div_tr - {1'b0, a0_q}) : div_tr[31:0];
		q_int  = dvd_q[81:16];
		q_cl   = (q_int > 66'h1_0000_0000) ? 33'h1_0000_0000 : q_int[32:0];
		q_sgn  = neg_q ? -$signed({1'b0, q_cl, dvd_q[15:0]})
		               :  $signed({1'b0, q_cl, dvd_q[15:0]});
		if (q_sgn > 50'sh0_7FFF_FFFF_FFFF)
			div_res = 48'sh7FFF_FFFF_FFFF;
		else if (q_sgn < -50'sh0_8000_0000_0000)
			div_res = 48'sh8000_0000_0000;
		else
			div_res = q_sgn[47:0];
	end

	// final effort sum and limits
	logic signed [65:0] eff_sum;
	logic signed [31:0] eff_lim;
	always_comb begin
		eff_sum = eff_q + 66'(prod_q16);
		if (eff_sum > 66'(upper_q))
			eff_lim = upper_q;
		else if (eff_sum < 66'(lower_q))
			eff_lim = lower_q;
		else
			eff_lim = eff_sum[31:0];
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidft_pkg::ST_IDLE;
			ch_q        <= 2'd0;
			cnt_q       <= 7'd0;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			warm_cnt_q  <= 2'd0;
			integ_q     <= '0;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			upper_q     <= 32'sh7FFF_FFFF;
			lower_q     <= 32'sh8000_0000;
			bound_q     <= 31'h7FFF_FFFF;
			period_q    <= 31'd66;
			coef_q      <= 24'sd65536;
			for (int i = 0; i < 3; i++) begin
				err_q[i] <= '0;
				fe_q[i]  <= '0;
				dh_q[i]  <= '0;
				fd_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_wr_en) begin
				case (pidft_pkg::cfg_reg_t'(cfg_idx))
					pidft_pkg::REG_GAIN_PROP:   kp_q     <= cfg_wdata;
					pidft_pkg::REG_GAIN_INTEG:  ki_q     <= cfg_wdata;
					pidft_pkg::REG_GAIN_DERIV:  kd_q     <= cfg_wdata;
					pidft_pkg::REG_EFF_UPPER:   upper_q  <= cfg_wdata;
					pidft_pkg::REG_EFF_LOWER:   lower_q  <= cfg_wdata;
					pidft_pkg::REG_INTEG_BOUND: bound_q  <= cfg_wdata[30:0];
					pidft_pkg::REG_PERIOD:      period_q <= cfg_wdata[30:0];
					pidft_pkg::REG_FILT_COEF:   coef_q   <= cfg_wdata[23:0];
					default: ;
				endcase
			end

			// slice counter runs only while a product is being built
			if (mul_on)
				ch_q <= ch_q + 2'd1;

			if (in_acc) begin
				err_q[2]  <= err_q[1];
				err_q[1]  <= err_q[0];
				err_q[0]  <= 33'(target) - 33'(measurement);
				started_q <= 1'b1;
			end

			if (state_q == pidft_pkg::ST_INTEG && mul_last)
				integ_q <= integ_new;

			if (state_q == pidft_pkg::ST_COEF) begin
				dh_q[2] <= dh_q[1];
				dh_q[1] <= dh_q[0];
				dh_q[0] <= diff_sat;
			end

			if ((state_q == pidft_pkg::ST_E_A1 || state_q == pidft_pkg::ST_D_A1) && mul_last)
				cnt_q <= 7'd0;
			else if ((state_q == pidft_pkg::ST_E_DIV || state_q == pidft_pkg::ST_D_DIV)
			         && !div_done)
				cnt_q <= cnt_q + 7'd1;

			if (state_q == pidft_pkg::ST_E_DIV && div_done) begin
				fe_q[2] <= fe_q[1];
				fe_q[1] <= fe_q[0];
				fe_q[0] <= div_res;
				if (!warm) begin
					// warm-up: hold the newest filtered difference
					fd_q[2]    <= fd_q[1];
					fd_q[1]    <= fd_q[0];
					warm_cnt_q <= warm_cnt_q + 2'd1;
				end
			end

			if (state_q == pidft_pkg::ST_D_DIV && div_done) begin
				fd_q[2] <= fd_q[1];
				fd_q[1] <= fd_q[0];
				fd_q[0] <= div_res;
			end

			// load a new result beat, else drop valid once the held beat is taken
			if (state_q == pidft_pkg::ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_on) begin
			pp_q  <= pp_d;
			acc_q <= acc_sum;
		end

		if (in_acc) begin
			res_eff_q    <= '0;
			res_primed_q <= started_q;
		end

		case (state_q)
			pidft_pkg::ST_CSQ: if (mul_last) c2_q <= prod_q16[29:0];
			pidft_pkg::ST_KC:  if (mul_last) kc_q <= prod_q16[24:0];
			pidft_pkg::ST_COEF: begin
				a0_q  <= (a0_raw < 33'sd1) ? 32'sd1 : a0_raw[31:0];
				a1_q  <= a1_new;
				a2_q  <= a2_new;
				num_q <= num_err;
			end
			pidft_pkg::ST_E_A2, pidft_pkg::ST_D_A2:
				if (mul_last) num_q <= num_fin;
			pidft_pkg::ST_E_A1, pidft_pkg::ST_D_A1:
				if (mul_last) begin
					neg_q <= num_fin[65];
					dvd_q <= {num_abs, 16'b0};
					rem_q <= '0;
				end
			pidft_pkg::ST_E_DIV, pidft_pkg::ST_D_DIV:
				if (!div_done) begin
					rem_q <= rem_n;
					dvd_q <= {dvd_q[80:0], div_ge};
				end else if (state_q == pidft_pkg::ST_E_DIV && warm) begin
					num_q <= num_diff;
				end
			pidft_pkg::ST_KP: if (mul_last) eff_q <= 66'(prod_q16);
			pidft_pkg::ST_KI: if (mul_last) eff_q <= eff_sum;
			pidft_pkg::ST_KD: if (mul_last) res_eff_q <= eff_lim;
			default: ;
		endcase

		if (state_q == pidft_pkg::ST_DONE && out_free) begin
			out_eff_q    <= res_eff_q;
			out_primed_q <= res_primed_q;
		end
	end

	// checks
	`CHK_NEXT(a_first_unprimed, clk, arst_n, in_acc && !started_q, state_q == pidft_pkg::ST_DONE && !res_primed_q)
	`CHK_IMPLY(a_valid_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == pidft_pkg::ST_DONE)
	`CHK_IMPLY(a_divisor_pos, clk, arst_n, state_q == pidft_pkg::ST_E_DIV || state_q == pidft_pkg::ST_D_DIV, a0_q > 32'sd0)
	`CHK_IMPLY(a_integ_bound, clk, arst_n, state_q == pidft_pkg::ST_COEF, 50'(integ_q) <= bound_ext && 50'(integ_q) >= -bound_ext)

endmodule

FILE: tb/pidft_checker.sv
`timescale 1ns / 1ps
// Scoreboard for pid_with_filtered_terms_unit: follows register writes and input beats,
// predicts each control effort and compares it with the output beat. Depends on pidft_pkg.
module pidft_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] measurement,
	input  logic signed [31:0] target,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] effort,
	input  logic               primed,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam longint ONE = 65536;
	localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint LMIN = -LMAX - 1;

	typedef struct {
		logic signed [31:0] effort;
		logic               primed;
	} effort_beat_t;

	effort_beat_t effort_q[$];

	longint kp, ki, kd_rate, upper, lower, ibound, period, coef;
	longint err[3], ferr[3], dif[3], fdif[3];
	longint integ;
	bit     started;
	int     warm;

	function automatic longint sat_w(longint x, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	// floor(a*f / 2^16), split so nothing overflows 64 bits
	function automatic longint mul_q16(longint a, longint f);
		longint fh, fl;
		fh = f >>> 16;
		fl = f - fh * ONE;
		return a * fh + ((a * fl) >>> 16);
	endfunction

	function automatic longint biquad(longint x0, longint x1, longint x2, longint y1,
			longint y2, longint a0, longint a1, longint a2);
		longint num, q, r, lim;
		num = x2 + 2 * x1 + x0 - mul_q16(a2, y2) - mul_q16(a1, y1);
		q = num / a0;
		r = num % a0;
		lim = longint'(1) <<< 32;
		if (q > lim) q = lim;
		if (q < -lim) q = -lim;
		return sat_w(q * ONE + (r * ONE) / a0, 48);
	endfunction

	task automatic clear_state();
		kp = 0; ki = 0; kd_rate = 0;
		upper = 64'sd2147483647; lower = -64'sd2147483648;
		ibound = 64'sd2147483647; period = 66; coef = ONE;
		for (int i = 0; i < 3; i++) begin
			err[i] = 0; ferr[i] = 0; dif[i] = 0; fdif[i] = 0;
		end
		integ = 0; started = 0; warm = 0;
	endtask

	task automatic predict_effort(longint meas, longint targ);
		effort_beat_t b;
		longint c, c2, kc, a0, a1, a2, p, d, eff;
		err[2] = err[1]; err[1] = err[0]; err[0] = targ - meas;
		b.effort = '0;
		b.primed = started;
		if (!started) begin
			started = 1;
		end else if (period != 0) begin
			integ += (err[0] * period) >>> 16;
			if (integ > ibound) integ = ibound;
			if (integ < -ibound) integ = -ibound;
			c = coef;
			if (c > longint'(pidft_pkg::C_MAX)) c = longint'(pidft_pkg::C_MAX);
			if (c < -longint'(pidft_pkg::C_MAX)) c = -longint'(pidft_pkg::C_MAX);
			c2 = (c * c) >>> 16;
			kc = (longint'(pidft_pkg::K_Q) * c) >>> 16;
			a0 = ONE + c2 + kc;
			a1 = 2 * ONE - 2 * c2;
			a2 = ONE + c2 - kc;
			if (a0 < 1) a0 = 1;
			ferr[2] = ferr[1]; ferr[1] = ferr[0];
			ferr[0] = biquad(err[0], err[1], err[2], ferr[1], ferr[2], a0, a1, a2);
			dif[2] = dif[1]; dif[1] = dif[0];
			dif[0] = sat_w(err[0] - err[1], 33);
			fdif[2] = fdif[1]; fdif[1] = fdif[0];
			// hold the newest filtered difference during warm-up
			if (warm >= pidft_pkg::WARMUP_DEFAULT)
				fdif[0] = biquad(dif[0], dif[1], dif[2], fdif[1], fdif[2], a0, a1, a2);
			else
				warm = (warm + 1) & 3;
			p = mul_q16(kp, ferr[0]) + ((ki * integ) >>> 16);
			d = mul_q16(kd_rate, fdif[0]);
			if (d > 0 && p > LMAX - d) eff = LMAX;
			else if (d < 0 && p < LMIN - d) eff = LMIN;
			else eff = p + d;
			if (eff > upper) eff = upper;
			else if (eff < lower) eff = lower;
			b.effort = eff[31:0];
		end
		effort_q.push_back(b);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		fail_count++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		effort_beat_t e;
		if (!arst_n) begin
			clear_state();
			effort_q.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (effort_q.size() == 0) begin
					report_mismatch("unexpected beat", effort, 0);
				end else begin
					e = effort_q.pop_front();
					checked++;
					if (effort !== e.effort)
						report_mismatch("effort", effort, e.effort);
					if (primed !== e.primed)
						report_mismatch("primed", primed, e.primed);
				end
			end
			if (in_valid && !in_stall)
				predict_effort(longint'(measurement), longint'(target));
			if (cfg_wr_en) begin
				case (pidft_pkg::cfg_reg_t'(cfg_idx))
					pidft_pkg::REG_GAIN_PROP:   kp = longint'($signed(cfg_wdata));
					pidft_pkg::REG_GAIN_INTEG:  ki = longint'($signed(cfg_wdata));
					pidft_pkg::REG_GAIN_DERIV:  kd_rate = longint'($signed(cfg_wdata));
					pidft_pkg::REG_EFF_UPPER:   upper = longint'($signed(cfg_wdata));
					pidft_pkg::REG_EFF_LOWER:   lower = longint'($signed(cfg_wdata));
					pidft_pkg::REG_INTEG_BOUND: ibound = longint'(cfg_wdata[30:0]);
					pidft_pkg::REG_PERIOD:      period = longint'(cfg_wdata[30:0]);
					pidft_pkg::REG_FILT_COEF:   coef = longint'($signed(cfg_wdata[23:0]));
					default: ;
				endcase
			end
		end
		pending = effort_q.size();
	end

endmodule

FILE: tb/tb_pid_with_filtered_terms_unit.sv
`timescale 1ns / 1ps
// Top of the testbench for pid_with_filtered_terms_unit: clock, reset, stimulus and verdict.
// Depends on pidft_pkg, the unit itself and pidft_checker.
module tb_pid_with_filtered_terms_unit;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] measurement;
	logic signed [31:0] target;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] effort;
	logic               primed;
	logic               cfg_wr_en;
	logic [2:0]         cfg_idx;
	logic [31:0]        cfg_wdata;

	int fail_count, pending, checked;
	int burst_left;
	int beats_sent;
	int stall_mode;

	pid_with_filtered_terms_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.measurement(measurement), .target(target),
		.out_valid(out_valid), .out_stall(out_stall),
		.effort(effort), .primed(primed),
		.cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	pidft_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.measurement(measurement), .target(target),
		.out_valid(out_valid), .out_stall(out_stall),
		.effort(effort), .primed(primed),
		.cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure: switch every so often between no stall, light random
	// stall, heavy random stall and long solid stretches.
	initial begin
		int left;
		out_stall = 0;
		left = 0;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				stall_mode = $urandom_range(0, 3);
				left = $urandom_range(50, 600);
			end
			left--;
			case (stall_mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 3) != 0);
				default: out_stall = ((left % 40) < 25);
			endcase
		end
	end

	// Write one register; the unit is idle whenever this is called.
	task automatic write_reg(pidft_pkg::cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
			logic [31:0] up, logic [31:0] lo, logic [31:0] ib, logic [31:0] per,
			logic [31:0] cf);
		write_reg(pidft_pkg::REG_GAIN_PROP, kp);
		write_reg(pidft_pkg::REG_GAIN_INTEG, ki);
		write_reg(pidft_pkg::REG_GAIN_DERIV, kd);
		write_reg(pidft_pkg::REG_EFF_UPPER, up);
		write_reg(pidft_pkg::REG_EFF_LOWER, lo);
		write_reg(pidft_pkg::REG_INTEG_BOUND, ib);
		write_reg(pidft_pkg::REG_PERIOD, per);
		write_reg(pidft_pkg::REG_FILT_COEF, cf);
	endtask

	// Present one beat and hold it until taken. Valid stays high inside a burst and
	// drops for a random gap between bursts.
	task automatic send_beat(logic [31:0] m, logic [31:0] t);
		@(negedge clk);
		measurement = m;
		target = t;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(0, 20)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
	endtask

	// Drop valid and let every expected beat come back before touching registers.
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Random gain: mostly modest Q16.16 values, now and then a full 32-bit one.
	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sd0;
			default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
		endcase
	endfunction

	// Random error source: plant near target with small noise, rare wild values.
	task automatic random_beat(int mode);
		logic [31:0] m, t;
		t = $urandom_range(0, 1) ? $signed($urandom_range(0, 200 * 65536)) - 100 * 65536
			: $urandom;
		case (mode)
			0: m = t + $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
			1: m = t + $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
			default: m = $urandom;
		endcase
		send_beat(m, t);
	endtask

	initial begin
		logic [31:0] up, lo;
		int n;
		arst_n = 0;
		in_valid = 0;
		measurement = 0;
		target = 0;
		cfg_wr_en = 0;
		cfg_idx = pidft_pkg::REG_GAIN_PROP;
		cfg_wdata = 0;
		beats_sent = 0;
		burst_left = 3;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: first beat under defaults (primed low, effort zero), then zero gains.
		send_beat(32'sd0, 32'sd0);
		send_beat(32'h7FFF_FFFF, 32'h8000_0000);
		drain();

		// Unit gains, wide open limits; drive error extremes and difference overflow.
		write_all(32'sd65536, 32'sd65536, 32'sd65536, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'sd65536, 32'sd65536);
		send_beat(32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(32'hFFFF_FFFF, 32'h0000_0000);
		send_beat(32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(32'h5555_5555, 32'hAAAA_AAAA);
		drain();

		// Huge gains so the effort sum saturates; zero integral bound; max period.
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
		send_beat(32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(32'h0, 32'h1);
		drain();

		// Coefficient beyond the clamp both ways, and inverted effort limits.
		write_all(32'sd131072, 32'sd65536, 32'h8000_0000, -32'sd65536, 32'sd65536,
			32'h7FFF_FFFF, 32'sd1, 32'h007F_FFFF);
		send_beat(32'sd1000000, -32'sd1000000);
		send_beat(-32'sd1000000, 32'sd1000000);
		send_beat(32'sd0, 32'sd0);
		drain();
		write_reg(pidft_pkg::REG_FILT_COEF, 32'h0080_0000);
		send_beat(32'sd1000000, -32'sd1000000);
		send_beat(-32'sd1000000, 32'sd1000000);
		drain();

		// Zero sample period: only the error history moves.
		write_reg(pidft_pkg::REG_PERIOD, 32'h0);
		send_beat(32'sd100, 32'sd5000);
		send_beat(32'sd200, 32'sd7000);
		drain();

		// Random phases: every register rewritten each time.
		for (int ph = 0; ph < 12; ph++) begin
			up = $urandom_range(0, 3) == 0 ? $urandom : 32'h7FFF_FFFF;
			lo = $urandom_range(0, 3) == 0 ? $urandom : 32'h8000_0000;
			write_all(pick_gain(), pick_gain(), pick_gain(), up, lo,
				($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1000 * 65536),
				(ph == 5) ? 32'h0 : (($urandom_range(0, 3) == 0) ? $urandom
					: $urandom_range(1, 65536)),
				($urandom_range(0, 4) == 0) ? $urandom
					: $signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
			n = $urandom_range(85, 105);
			for (int i = 0; i < n; i++)
				random_beat(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2));
			drain();
		end

		repeat (300) @(negedge clk);
		$display("Sent %0d beats over directed and 12 random register settings, %0d compared.",
			beats_sent, checked);
		$display("Covered extremes, clamped coefficient, inverted limits, zero period.");
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#30_000_000;
		$display("Timed out with %0d results outstanding.", pending);
		$display("TEST FAILED");
		$finish;
	end

endmodule
